FILE: rtl/rcke_pkg.sv
// Shared types, constants and the raised-cosine envelope table for the keying envelope.
// No dependencies; used by every module of the block.
`default_nettype none

package rcke_pkg;

    // Table and phase geometry
    localparam int TABLE_ENTRIES = 256;
    localparam int FRAC_W        = 16;
    localparam int ROM_LAST      = TABLE_ENTRIES - 1;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int PHASE_W       = IDX_W + FRAC_W;
    localparam int ENV_W         = 17;
    localparam int TAYLOR_TERMS  = 16;

    localparam logic [PHASE_W-1:0] PHASE_FULL = {IDX_W'(ROM_LAST), FRAC_W'(0)};

    // Configuration port
    localparam int STEP_W     = 24;
    localparam int CODE_W     = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_NULL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_FULL  = 2'd2;

    localparam logic [STEP_W-1:0] PHASE_STEP_RST = 24'd83558;
    localparam logic [CODE_W-1:0] CODE_NULL_RST  = 12'h000;
    localparam logic [CODE_W-1:0] CODE_FULL_RST  = 12'hFFF;

    // DAC word layout
    localparam int           WORD_W     = 16;
    localparam logic [3:0]   WORD_CMD   = 4'h3;
    localparam int           SCALE_SHIFT = 16;
    localparam int           DIFF_W     = CODE_W + 1;

    // Serial multiplier geometry: unsigned multiplier, signed multiplicand
    localparam int MUL_W   = ENV_W;
    localparam int MCAND_W = ENV_W + 1;
    localparam int PROD_W  = MCAND_W + 1 + MUL_W;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_INTERP_GO,
        ST_INTERP,
        ST_SCALE_GO,
        ST_SCALE,
        ST_EMIT
    } rcke_state_t;

    // Status from the phase unit to the sequencer
    typedef struct packed {
        logic              active;
        logic              done;
        logic [FRAC_W-1:0] frac;
        logic [ENV_W-1:0]  rom_a;
        logic [ENV_W-1:0]  rom_d;
    } ph_stat_t;

    typedef logic [TABLE_ENTRIES-1:0][ENV_W-1:0] rom_arr_t;

    localparam logic [63:0] PI_HALF_Q62 = 64'h6487ED5110B4611A;
    localparam logic [63:0] ROM_LAST64  = 64'(ROM_LAST);
    localparam logic [63:0] ANGLE_Q     = PI_HALF_Q62 / ROM_LAST64;
    localparam logic [63:0] ANGLE_R     = PI_HALF_Q62 % ROM_LAST64;

    // (a*b) >> 62 with a full 128-bit product
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Unsigned 64-bit restoring division, used only while building the table
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sin(x)^2 table, x = (pi/2)*i/ROM_LAST, evaluated by a Taylor series in Q62
    function automatic rom_arr_t build_rom();
        rom_arr_t    rom;
        logic [63:0] i64;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] s2;
        logic [63:0] dv;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            i64  = 64'(i);
            x    = ANGLE_Q * i64 + div_u64(ANGLE_R * i64, ROM_LAST64);
            x2   = mul_q62(x, x);
            term = x;
            sum  = x;
            for (int k = 1; k < TAYLOR_TERMS; k++) begin
                dv   = 64'(2 * k) * 64'(2 * k + 1);
                term = div_u64(mul_q62(term, x2), dv);
                if ((k & 1) == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            s2     = mul_q62(sum, sum);
            s2     = (s2 + (64'd1 << 45)) >> 46;
            rom[i] = s2[ENV_W-1:0];
        end
        return rom;
    endfunction

    localparam rom_arr_t ENVELOPE_ROM = build_rom();

endpackage

`default_nettype wire

FILE: rtl/raised_cosine_keying_envelope.sv
// Raised-cosine keying envelope: one DAC word per active key tick.
// Each working tick runs a phase update, a table fetch and two bit-serial multiplies
// (interpolation, then code scaling) before its word is registered and m_valid rises.
// New ticks wait until the word enters the output register; idle key-up ticks drop.
// Reset (aresetn, synchronous, active low): idle, phase zero, registers to defaults.
`default_nettype none

module raised_cosine_keying_envelope (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [rcke_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcke_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_key_level,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rcke_pkg::WORD_W-1:0]     m_dac_word,
    output logic                            m_run_done
);
    import rcke_pkg::*;

    rcke_state_t          state_reg, state_next;
    logic [STEP_W-1:0]    step_reg;
    logic [CODE_W-1:0]    null_reg;
    logic [CODE_W-1:0]    full_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]    m_dac_word_reg;
    logic                 m_run_done_reg;

    ph_stat_t             ph;
    logic                 accept;
    logic                 go;
    logic                 out_load;
    logic                 mul_start;
    logic                 mul_busy;
    logic                 mul_done;
    logic [MUL_W-1:0]     mul_mplier;
    logic signed [MCAND_W-1:0] mul_mcand;
    logic signed [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]    interp_rnd;
    logic [ENV_W-1:0]     env;
    logic signed [DIFF_W-1:0]  diff;
    logic [PROD_W-1:0]    scale_rnd;
    logic [CODE_W-1:0]    code;

    // Configuration writes; unknown indexes drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= PHASE_STEP_RST;
            null_reg <= CODE_NULL_RST;
            full_reg <= CODE_FULL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PHASE_STEP: step_reg <= cfg_wdata[STEP_W-1:0];
                REG_CODE_NULL:  null_reg <= cfg_wdata[CODE_W-1:0];
                REG_CODE_FULL:  full_reg <= cfg_wdata[CODE_W-1:0];
                default:        ;
            endcase
        end
    end

    rcke_phase u_phase (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .go         (go),
        .key_level  (s_key_level),
        .phase_step (step_reg),
        .stat       (ph)
    );

    rcke_serial_mul #(
        .MW (MUL_W),
        .CW (MCAND_W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mplier  (mul_mplier),
        .mcand   (mul_mcand),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (prod)
    );

    // Interpolated envelope from the first product and scaled code from the second, rounded
    always_comb begin
        interp_rnd = prod + (PROD_W'(1) << (FRAC_W - 1));
        env        = ph.rom_a + interp_rnd[FRAC_W +: ENV_W];
        diff       = $signed({1'b0, full_reg}) - $signed({1'b0, null_reg});
        scale_rnd  = prod + (PROD_W'(1) << (SCALE_SHIFT - 1));
        code       = null_reg + scale_rnd[SCALE_SHIFT +: CODE_W];
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (go) state_next = ST_FETCH;
            ST_FETCH:     state_next = ST_INTERP_GO;
            ST_INTERP_GO: state_next = ST_INTERP;
            ST_INTERP:    if (mul_done) state_next = ST_SCALE_GO;
            ST_SCALE_GO:  state_next = ST_SCALE;
            ST_SCALE:     if (mul_done) state_next = ST_EMIT;
            ST_EMIT:      if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_ready    = 1'b0;
        mul_start  = 1'b0;
        out_load   = 1'b0;
        mul_mplier = {{(MUL_W - FRAC_W){1'b0}}, ph.frac};
        mul_mcand  = {1'b0, ph.rom_d};
        case (state_reg)
            ST_IDLE:      s_ready = 1'b1;
            ST_INTERP_GO: mul_start = 1'b1;
            ST_SCALE_GO: begin
                mul_start  = 1'b1;
                mul_mplier = env;
                mul_mcand  = {{(MCAND_W - DIFF_W){diff[DIFF_W-1]}}, diff};
            end
            ST_EMIT:      out_load = !m_valid_reg || m_ready;
            default:      ;
        endcase
    end

    assign accept = s_valid && s_ready;
    // Drop key-up ticks while idle
    assign go     = accept && (ph.active || s_key_level);

    // Output register: hold until taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_dac_word_reg <= {WORD_CMD, code};
            m_run_done_reg <= ph.done;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_dac_word = m_dac_word_reg;
    assign m_run_done = m_run_done_reg;

    // No tick is taken while a multiply is in flight
    a_ready_mul_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !mul_busy)
        else $error("input ready during multiply");

    // Multiply completions only come back to a waiting state
    a_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_INTERP || state_reg == ST_SCALE))
        else $error("multiply done in unexpected state");

    // A word that ends the run leaves the block idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && ph.done |=> !ph.active)
        else $error("run ended but block still active");

endmodule

`default_nettype wire

FILE: rtl/rcke_serial_mul.sv
// Bit-serial shift-add multiplier: unsigned multiplier times signed multiplicand.
// One multiplier bit per cycle; depends on rcke_pkg for default widths.
`default_nettype none

module rcke_serial_mul #(
    parameter int MW = rcke_pkg::MUL_W,
    parameter int CW = rcke_pkg::MCAND_W
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [MW-1:0]        mplier,
    input  logic signed [CW-1:0] mcand,
    output logic                 busy,
    output logic                 done,
    output logic signed [CW+MW:0] product
);
    import rcke_pkg::*;

    localparam int CNT_W = $clog2(MW + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic signed [CW:0]   hi_reg, hi_next;
    logic [MW-1:0]        lo_reg, lo_next;
    logic signed [CW-1:0] mcand_reg, mcand_next;
    logic signed [CW:0]   addend;
    logic signed [CW:0]   sum;

    // Add the multiplicand when the current multiplier bit is set
    always_comb begin
        addend = lo_reg[0] ? {mcand_reg[CW-1], mcand_reg} : '0;
        sum    = hi_reg + addend;
    end

    // Load on start, then shift one bit per cycle
    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        mcand_next = mcand_reg;
        if (start) begin
            busy_next  = 1'b1;
            cnt_next   = CNT_W'(MW);
            hi_next    = '0;
            lo_next    = mplier;
            mcand_next = mcand;
        end else if (busy_reg) begin
            hi_next  = {sum[CW], sum[CW:1]};
            lo_next  = {sum[0], lo_reg[MW-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        mcand_reg <= mcand_next;
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

    // A new operand pair never lands on a running product
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("multiplier started while busy");

endmodule

`default_nettype wire

FILE: rtl/rcke_phase.sv
// Phase accumulator with saturation, run tracking and envelope table lookup.
// Depends on rcke_pkg for geometry, the table and the status struct.
`default_nettype none

module rcke_phase (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        go,
    input  logic                        key_level,
    input  logic [rcke_pkg::STEP_W-1:0] phase_step,
    output rcke_pkg::ph_stat_t          stat
);
    import rcke_pkg::*;

    localparam int SUM_W = ((PHASE_W > STEP_W) ? PHASE_W : STEP_W) + 1;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               active_reg, active_next;
    logic               done_reg, done_next;
    logic [ENV_W-1:0]   rom_a_reg, rom_a_next;
    logic [ENV_W-1:0]   rom_d_reg, rom_d_next;
    logic [SUM_W-1:0]   ph_ext;
    logic [SUM_W-1:0]   step_ext;
    logic [SUM_W-1:0]   up_sum;
    logic [SUM_W-1:0]   dn_dif;
    logic [PHASE_W-1:0] phase_upd;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   idx_nxt;

    // Step toward the key level, saturating at zero and full scale
    always_comb begin
        ph_ext   = SUM_W'(phase_reg);
        step_ext = SUM_W'(phase_step);
        up_sum   = ph_ext + step_ext;
        dn_dif   = ph_ext - step_ext;
        if (key_level) begin
            phase_upd = (up_sum > SUM_W'(PHASE_FULL)) ? PHASE_FULL : up_sum[PHASE_W-1:0];
        end else begin
            phase_upd = (step_ext >= ph_ext) ? '0 : dn_dif[PHASE_W-1:0];
        end
    end

    // Advance the run on each transaction that does work
    always_comb begin
        phase_next  = phase_reg;
        active_next = active_reg;
        done_next   = done_reg;
        if (go) begin
            phase_next  = phase_upd;
            done_next   = !key_level && (phase_upd == '0);
            active_next = !done_next;
        end
    end

    // Fetch the entry pair around the current phase; the last entry pairs with itself
    always_comb begin
        idx        = phase_reg[PHASE_W-1:FRAC_W];
        idx_nxt    = (idx == IDX_W'(ROM_LAST)) ? idx : idx + 1'b1;
        rom_a_next = ENVELOPE_ROM[idx];
        rom_d_next = ENVELOPE_ROM[idx_nxt] - ENVELOPE_ROM[idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= '0;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rom_a_reg <= rom_a_next;
        rom_d_reg <= rom_d_next;
    end

    assign stat.active = active_reg;
    assign stat.done   = done_reg;
    assign stat.frac   = phase_reg[FRAC_W-1:0];
    assign stat.rom_a  = rom_a_reg;
    assign stat.rom_d  = rom_d_reg;

    // Phase stays within the table
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= PHASE_FULL)
        else $error("phase beyond full scale");

    // An idle block rests at zero phase
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> (phase_reg == '0))
        else $error("idle with nonzero phase");

endmodule

`default_nettype wire
